@@ design/ucsum_pkg.sv @@
// ucsum_pkg: shared types, register map and ones'-complement helpers
// for the UDP/IPv4 checksum block. No dependencies.
`timescale 1ns / 1ps

package ucsum_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_PSEUDO_EN = 2'd0,
        REG_SRC_ADDR  = 2'd1,
        REG_DST_ADDR  = 2'd2,
        REG_PROTOCOL  = 2'd3
    } t_reg_idx;

    localparam logic       PSEUDO_EN_RST = 1'b1;
    localparam logic [7:0] PROTOCOL_RST  = 8'd17;

    // valid_bytes codes (3 behaves as a full word)
    localparam logic [1:0] VB_NONE = 2'd0;
    localparam logic [1:0] VB_ONE  = 2'd1;

    // Static configuration seen by the datapath
    typedef struct packed {
        logic        pseudo_en;
        logic [15:0] cfg_sum;   // folded sum of address and protocol words
    } t_cfg;

    // Ones'-complement add with end-around carry; 0 + 0 stays 0
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Fold a sum of up to eight words to 16 bits; zero only for zero
    function automatic logic [15:0] fold19(input logic [18:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

@@ design/ucsum_regs.sv @@
// ucsum_regs: APB register file and precomputed pseudo-header sum.
// Depends on ucsum_pkg.
`timescale 1ns / 1ps

module ucsum_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ucsum_pkg::ADDR_W-1:0]   paddr,
    input  logic [ucsum_pkg::DATA_W-1:0]   pwdata,
    output logic [ucsum_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    output ucsum_pkg::t_cfg                o_cfg
);

    logic        r_pseudo_en;
    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [7:0]  r_protocol;
    logic [15:0] r_cfg_sum;

    logic                  wr_en;
    ucsum_pkg::t_reg_idx   reg_idx;
    logic [18:0]           n_cfg_raw;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = ucsum_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pseudo_en <= ucsum_pkg::PSEUDO_EN_RST;
            r_src_addr  <= '0;
            r_dst_addr  <= '0;
            r_protocol  <= ucsum_pkg::PROTOCOL_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                ucsum_pkg::REG_PSEUDO_EN: r_pseudo_en <= pwdata[0];
                ucsum_pkg::REG_SRC_ADDR:  r_src_addr  <= pwdata;
                ucsum_pkg::REG_DST_ADDR:  r_dst_addr  <= pwdata;
                ucsum_pkg::REG_PROTOCOL:  r_protocol  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ucsum_pkg::REG_PSEUDO_EN: prdata = {31'd0, r_pseudo_en};
            ucsum_pkg::REG_SRC_ADDR:  prdata = r_src_addr;
            ucsum_pkg::REG_DST_ADDR:  prdata = r_dst_addr;
            ucsum_pkg::REG_PROTOCOL:  prdata = {24'd0, r_protocol};
            default:                  prdata = '0;
        endcase
    end

    // Constant part of the pseudo-header, refreshed every cycle
    assign n_cfg_raw = {3'd0, r_src_addr[31:16]} + {3'd0, r_src_addr[15:0]}
                     + {3'd0, r_dst_addr[31:16]} + {3'd0, r_dst_addr[15:0]}
                     + {11'd0, r_protocol};

    always_ff @(posedge i_clk) begin
        r_cfg_sum <= ucsum_pkg::fold19(n_cfg_raw);
    end

    assign o_cfg.pseudo_en = r_pseudo_en;
    assign o_cfg.cfg_sum   = r_cfg_sum;

endmodule

@@ design/ucsum_core.sv @@
// ucsum_core: input register, running sum / byte count, result register.
// Depends on ucsum_pkg.
`timescale 1ns / 1ps

module ucsum_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ucsum_pkg::t_cfg i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [15:0]     i_data_word,
    input  logic [1:0]      i_valid_bytes,
    input  logic            i_last_word,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [15:0]     o_checksum,
    output logic [15:0]     o_byte_length
);

    logic        r_in_valid;
    logic [15:0] r_in_word;
    logic [1:0]  r_in_vb;
    logic        r_in_last;

    logic [15:0] r_sum;
    logic [15:0] r_cnt;

    logic        r_out_valid;
    logic [15:0] r_checksum;
    logic [15:0] r_byte_length;

    logic        out_free;
    logic        adv;
    logic        in_accept;
    logic [1:0]  step;
    logic [15:0] word_m;
    logic [15:0] n_sum;
    logic [15:0] n_cnt;
    logic [18:0] fin_raw;
    logic [15:0] n_checksum;

    // A last word may only leave when the result register can take it
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (r_in_vb)
            ucsum_pkg::VB_NONE: step = 2'd0;
            ucsum_pkg::VB_ONE:  step = 2'd1;
            default:            step = 2'd2;
        endcase
    end

    assign word_m = (r_in_vb == ucsum_pkg::VB_ONE) ? {r_in_word[15:8], 8'd0} : r_in_word;
    assign n_sum  = (step != 2'd0) ? ucsum_pkg::oc_add(r_sum, word_m) : r_sum;
    assign n_cnt  = r_cnt + {14'd0, step};

    assign fin_raw = {3'd0, n_sum}
                   + (i_cfg.pseudo_en ? ({3'd0, i_cfg.cfg_sum} + {3'd0, n_cnt}) : 19'd0);
    assign n_checksum = ~ucsum_pkg::fold19(fin_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_sum <= r_in_last ? 16'd0 : n_sum;
                r_cnt <= r_in_last ? 16'd0 : n_cnt;
            end
            if (adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_data_word;
            r_in_vb   <= i_valid_bytes;
            r_in_last <= i_last_word;
        end
        if (adv && r_in_last) begin
            r_checksum    <= n_checksum;
            r_byte_length <= n_cnt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_checksum    = r_checksum;
    assign o_byte_length = r_byte_length;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> r_out_valid)
        else $error("last word advanced without a result");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_sum == 16'd0 && r_cnt == 16'd0))
        else $error("running state not cleared after packet end");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

@@ design/udp_ipv4_checksum.sv @@
// udp_ipv4_checksum: top level of the streaming Internet checksum block.
// Depends on ucsum_pkg, ucsum_regs and ucsum_core.
`timescale 1ns / 1ps

// Streaming RFC 1071 checksum with optional UDP pseudo-header. Packet data
// arrives as 16-bit network-order words (first byte in the high half), one
// transaction per clock at full rate: an accepted word lands in an input
// register and from there is folded into a ones'-complement running sum and
// a byte count, so a new word is taken every cycle unless a last word waits
// for the result register. A valid_bytes of 1 keeps only the high byte; 0
// adds nothing; 3 counts as 2. On the word flagged last, the pseudo-header
// (both addresses, the protocol and the byte count modulo 65536) is added
// when enabled, the sum is folded and inverted, and checksum plus byte_length
// are loaded into the result register as the last word leaves the input
// register. Zero is reported as zero, not as 0xFFFF. Only the last word
// needs the result register; while a result waits under stall, ordinary
// words keep flowing and only a following last word holds the input stage.
// The address and protocol part of the pseudo-header is pre-summed in a
// register in the cycle after each write. Registers (APB, byte address 4*i):
// 0 pseudo_header_enable (reset 1), 1 source_address, 2 destination_address,
// 3 protocol_number (reset 17). Write them only while the block is idle.

module udp_ipv4_checksum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ucsum_pkg::ADDR_W-1:0] paddr,
    input  logic [ucsum_pkg::DATA_W-1:0] pwdata,
    output logic [ucsum_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    // packet words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [15:0]                  i_data_word,
    input  logic [1:0]                   i_valid_bytes,
    input  logic                         i_last_word,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [15:0]                  o_checksum,
    output logic [15:0]                  o_byte_length
);

    ucsum_pkg::t_cfg cfg;

    ucsum_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ucsum_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_checksum    (o_checksum),
        .o_byte_length (o_byte_length)
    );

endmodule

@@ sim/tb_udp_ipv4_checksum.sv @@
// tb_udp_ipv4_checksum: self-checking testbench for the streaming UDP/IPv4 checksum block.
// Depends on ucsum_pkg and udp_ipv4_checksum; drives the APB registers and both
// valid/stall channels, and checks results against an in-bench checksum predictor.
`timescale 1ns / 1ps

module tb_udp_ipv4_checksum;

    // valid_bytes codes not named in the package
    localparam logic [1:0] VB_TWO  = 2'd2;
    localparam logic [1:0] VB_OVER = 2'd3;   // oversized count, behaves as two bytes

    localparam int PHASE_ITEMS = 185;        // random words per configuration phase, at least
    localparam int DRAIN_GAP   = 4;          // idle edges before a register write

    typedef struct packed {
        logic [15:0] csum;
        logic [15:0] len;
    } t_csum_result;

    // One row of the directed table; typed=1 means the expected result is given inline
    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  nb;
        logic        last;
        logic        typed;
        logic [15:0] csum;
        logic [15:0] len;
    } t_stim_row;

    // ---------------------------------------------------------------------------
    // Clock, reset and DUT-facing signals (the driven ones known from time zero)
    // ---------------------------------------------------------------------------
    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [ucsum_pkg::ADDR_W-1:0] paddr         = '0;
    logic [ucsum_pkg::DATA_W-1:0] pwdata        = '0;
    logic [ucsum_pkg::DATA_W-1:0] prdata;
    logic                         pready;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic [15:0]                  i_data_word   = '0;
    logic [1:0]                   i_valid_bytes = ucsum_pkg::VB_NONE;
    logic                         i_last_word   = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic [15:0]                  o_checksum;
    logic [15:0]                  o_byte_length;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    udp_ipv4_checksum u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_checksum    (o_checksum),
        .o_byte_length (o_byte_length)
    );

    // ---------------------------------------------------------------------------
    // Checksum predictor: shadow registers plus running sum and byte count
    // ---------------------------------------------------------------------------
    logic         ph_en    = ucsum_pkg::PSEUDO_EN_RST;
    logic [31:0]  src_ip   = '0;
    logic [31:0]  dst_ip   = '0;
    logic [7:0]   proto    = ucsum_pkg::PROTOCOL_RST;
    logic [15:0]  acc_sum  = '0;
    logic [15:0]  byte_cnt = '0;

    t_csum_result csum_expect_q[$];   // checksums owed by the DUT, oldest first
    int           err_count = 0;
    logic         jitter_on = 1'b0;   // random idling on both channels
    int unsigned  stall_left = 0;

    // End-around-carry add, kept folded to 16 bits
    function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned t;
        t = 32'(a) + 32'(b);
        t = (t & 32'h0000_FFFF) + (t >> 16);
        return t[15:0];
    endfunction

    // Fold one accepted word into the shadow state; on the last word queue the
    // checksum (or the inline value from the directed table) and clear the state.
    task automatic track_word(input logic [15:0] w, input logic [1:0] nb, input logic lw,
                              input logic typed, input t_csum_result typed_res);
        logic [15:0] s;
        logic [1:0]  n;
        n = (nb == VB_OVER) ? VB_TWO : nb;
        if (n == ucsum_pkg::VB_ONE)
            w[7:0] = 8'h00;                      // lone byte sits in the high half
        if (n != ucsum_pkg::VB_NONE) begin
            acc_sum  = csum_add(acc_sum, w);
            byte_cnt = byte_cnt + {14'd0, n};    // wraps modulo 65536
        end
        if (lw) begin
            s = acc_sum;
            if (ph_en) begin
                s = csum_add(s, src_ip[31:16]);
                s = csum_add(s, src_ip[15:0]);
                s = csum_add(s, dst_ip[31:16]);
                s = csum_add(s, dst_ip[15:0]);
                s = csum_add(s, {8'h00, proto});
                s = csum_add(s, byte_cnt);
            end
            if (typed)
                csum_expect_q.push_back(typed_res);
            else
                csum_expect_q.push_back({~s, byte_cnt});
            acc_sum  = '0;
            byte_cnt = '0;
        end
    endtask

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------------------------------------------------------------------
    // Result side: random stall bursts, results checked at the falling
    // edge where everything the next rising edge acts on is settled.
    // ---------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!jitter_on) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(1, 15);
            i_out_stall <= 1'b1;
        end
    end

    always @(negedge i_clk) begin : result_check
        t_csum_result e;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (csum_expect_q.size() == 0) begin
                flag_error($sformatf("unexpected result checksum=%h length=%0d",
                                     o_checksum, o_byte_length));
            end else begin
                e = csum_expect_q.pop_front();
                if (o_checksum !== e.csum)
                    flag_error($sformatf("checksum got %h want %h", o_checksum, e.csum));
                if (o_byte_length !== e.len)
                    flag_error($sformatf("byte_length got %0d want %0d",
                                         o_byte_length, e.len));
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Packet side
    // ---------------------------------------------------------------------------
    // Offer one word (after an optional idle burst) and hold it until taken.
    // The stall is sampled at the falling edge, so the transaction completes at
    // the following rising edge, where this task returns.
    task automatic put_word(input logic [15:0] w, input logic [1:0] nb, input logic lw,
                            input logic typed, input t_csum_result typed_res);
        logic taken;
        if (jitter_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_word   <= w;
        i_valid_bytes <= nb;
        i_last_word   <= lw;
        do begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        track_word(w, nb, lw, typed, typed_res);
    endtask

    // Block goes idle: no word offered, every checksum delivered, pipeline empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (csum_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // APB write: setup then access; the register takes the data at the access edge.
    // The bus is left idle after each transfer before the task returns.
    task automatic apb_write(input ucsum_pkg::t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(negedge i_clk);
        while (pready !== 1'b1);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ucsum_pkg::REG_PSEUDO_EN: ph_en  = val[0];
            ucsum_pkg::REG_SRC_ADDR:  src_ip = val;
            ucsum_pkg::REG_DST_ADDR:  dst_ip = val;
            ucsum_pkg::REG_PROTOCOL:  proto  = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Upper bits of the narrow registers carry junk; only the low bits count
    task automatic program_regs(input logic en, input logic [31:0] src,
                                input logic [31:0] dst, input logic [7:0] prot);
        apb_write(ucsum_pkg::REG_PSEUDO_EN, ($urandom() & 32'hFFFF_FFFE) | {31'd0, en});
        apb_write(ucsum_pkg::REG_SRC_ADDR, src);
        apb_write(ucsum_pkg::REG_DST_ADDR, dst);
        apb_write(ucsum_pkg::REG_PROTOCOL, ($urandom() & 32'hFFFF_FF00) | {24'd0, prot});
    endtask

    // Random packets: mostly well formed (full words, a lone byte or odd tail now and then),
    // about one in eight is noise with arbitrary byte counts and early ends.
    task automatic run_phase(input int n_items);
        int          sent;
        int          plen;
        bit          noisy;
        logic [15:0] w;
        logic [1:0]  nb;
        logic        lw;
        sent = 0;
        while (sent < n_items) begin
            plen  = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 16);
            noisy = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < plen; i++) begin
                w = 16'($urandom_range(0, 16'hFFFF));
                if ($urandom_range(0, 15) == 0)
                    w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                lw = (i == plen - 1);
                if (noisy) begin
                    nb = 2'($urandom_range(0, 3));
                    lw = lw || ($urandom_range(0, 7) == 0);
                end else begin
                    nb = ($urandom_range(0, 19) == 0) ? ucsum_pkg::VB_ONE : VB_TWO;
                    if (lw && $urandom_range(0, 2) == 0)
                        nb = 2'($urandom_range(0, 3));
                end
                put_word(w, nb, lw, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------
    initial begin : main_seq
        t_stim_row rows[$];

        repeat (2) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        jitter_on <= 1'b1;

        // Directed table, run with reset configuration (pseudo-header on, both
        // addresses zero, protocol 17), so a one-word packet sums to
        // word + 0x0011 + byte count before inversion.
        rows.push_back({16'h0000, ucsum_pkg::VB_NONE, 1'b1, 1'b1, 16'hFFEE, 16'd0}); // empty
        rows.push_back({16'hFFFF, VB_TWO,  1'b1, 1'b1, 16'hFFEC, 16'd2}); // all-ones word
        rows.push_back({16'h0000, VB_TWO,  1'b1, 1'b1, 16'hFFEC, 16'd2}); // zero word
        rows.push_back({16'hFFEC, VB_TWO,  1'b1, 1'b1, 16'h0000, 16'd2}); // zero checksum kept
        rows.push_back({16'hABCD, ucsum_pkg::VB_ONE, 1'b1, 1'b1, 16'h54ED, 16'd1}); // lone byte
        rows.push_back({16'h00FF, ucsum_pkg::VB_ONE, 1'b1, 1'b1, 16'hFFED, 16'd1}); // low masked
        rows.push_back({16'h1234, VB_OVER, 1'b1, 1'b1, 16'hEDB8, 16'd2}); // count 3 as 2
        // lone byte mid-packet
        rows.push_back({16'h1234, ucsum_pkg::VB_ONE,  1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'h5678, VB_TWO,  1'b1, 1'b0, 16'h0000, 16'd0});
        // empty word mid-packet, then oversized count at the end
        rows.push_back({16'hFFFF, ucsum_pkg::VB_NONE, 1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'h8001, VB_TWO,  1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'h7FFF, VB_OVER, 1'b1, 1'b0, 16'h0000, 16'd0});
        // carry chain
        rows.push_back({16'hFFFF, VB_TWO,  1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'hFFFF, VB_TWO,  1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'h0001, VB_TWO,  1'b1, 1'b0, 16'h0000, 16'd0});
        // mixed counts, odd total
        rows.push_back({16'hA5A5, VB_TWO,  1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'h5A5A, ucsum_pkg::VB_NONE, 1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'hFFFF, ucsum_pkg::VB_ONE,  1'b1, 1'b0, 16'h0000, 16'd0});
        // packet that ends on an empty word
        rows.push_back({16'hC3C3, VB_TWO,  1'b0, 1'b0, 16'h0000, 16'd0});
        rows.push_back({16'h3C3C, ucsum_pkg::VB_NONE, 1'b1, 1'b0, 16'h0000, 16'd0});

        foreach (rows[k])
            put_word(rows[k].word, rows[k].nb, rows[k].last, rows[k].typed,
                     {rows[k].csum, rows[k].len});

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: program_regs(1'b0, $urandom(), $urandom(), 8'($urandom_range(0, 255)));
                1: program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
                2: program_regs(1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00);
                3: program_regs(1'b1, $urandom(), $urandom(), ucsum_pkg::PROTOCOL_RST);
                4: program_regs(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
                default: program_regs(1'b1, $urandom(), $urandom(),
                                      8'($urandom_range(0, 255)));
            endcase
            run_phase(PHASE_ITEMS);
        end

        // Closing stretch at full rate on both sides, no idling
        drain();
        jitter_on <= 1'b0;
        program_regs(1'b1, $urandom(), $urandom(), 8'($urandom_range(0, 255)));
        run_phase(PHASE_ITEMS);

        drain();
        if (err_count == 0)
            $display("PASS udp_ipv4_checksum");
        else
            $display("FAIL udp_ipv4_checksum");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(64'd20_000_000);
        $display("FAIL udp_ipv4_checksum");
        $finish;
    end

endmodule

@@ sim.f @@
design/ucsum_pkg.sv
design/ucsum_regs.sv
design/ucsum_core.sv
design/udp_ipv4_checksum.sv
sim/tb_udp_ipv4_checksum.sv
